@@ hdl/c3zs_pkg.sv @@
// shared types and constants for the 3x3 zero-padded convolution stream
package c3zs_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int PIX_W      = 16;
	localparam int COEF_W     = 8;
	localparam int TAPS       = 3;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int FW_W   = COL_W + 1;
	localparam int FH_W   = ROW_W + 1;
	localparam int KROW_W = 8 * TAPS;
	localparam int PROD_W = PIX_W + COEF_W;
	localparam int RSUM_W = PROD_W + 1;
	localparam int OUT_W  = RSUM_W + 2;

	localparam int OUT_FIELDS_W = OUT_W + ROW_W + COL_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int IN_TDATA_W   = ((PIX_W + 7) / 8) * 8;
	localparam int APB_ADDR_W   = 5;
	localparam int APB_DATA_W   = 32;

	localparam logic [FW_W-1:0]   FRAME_WIDTH_RST  = FW_W'(MAX_WIDTH);
	localparam logic [FH_W-1:0]   FRAME_HEIGHT_RST = FH_W'(MAX_HEIGHT);
	localparam logic [KROW_W-1:0] KROW_RST         = KROW_W'(24'h010101);

	typedef logic signed [PIX_W-1:0]  pixel_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [RSUM_W-1:0] rsum_t;
	typedef logic signed [OUT_W-1:0]  fsum_t;
	typedef logic [KROW_W-1:0]        krow_t;

	typedef enum logic [2:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_KERNEL_TOP   = 3'd2,
		REG_KERNEL_MID   = 3'd3,
		REG_KERNEL_BOT   = 3'd4
	} reg_idx_t;

	// per-cycle instruction for one window row cell
	typedef struct packed {
		logic active;  // kernel row applies to this window row
		logic dc;      // take taps one column to the right
		logic zleft;   // left column lies outside the frame
	} cell_ctl_t;

endpackage

@@ hdl/c3zs_ram.sv @@
// generic simple dual-port ram with registered read
module c3zs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/c3zs_cell.sv @@
// one window row: three taps, three coefficient products and a row sum
module c3zs_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 shift,
	input  logic                 adv,
	input  c3zs_pkg::pixel_t     tap_in,
	input  c3zs_pkg::krow_t      coef_row,
	input  c3zs_pkg::cell_ctl_t  ctl,
	output c3zs_pkg::rsum_t      row_sum
);
	import c3zs_pkg::*;

	pixel_t tap_q   [TAPS];
	prod_t  prod_c  [TAPS];
	prod_t  prod_s3 [TAPS];
	rsum_t  row_sum_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '{default: '0};
		end else if (shift) begin
			tap_q[0] <= tap_q[1];
			tap_q[1] <= tap_q[2];
			tap_q[2] <= tap_in;
		end
	end

	for (genvar c = 0; c < TAPS; c++) begin : g_tap
		logic signed [COEF_W-1:0] coef;
		pixel_t                   tap_sel;
		logic                     tap_en;

		assign coef = coef_row[8*c +: COEF_W];

		if (c == TAPS - 1) begin : g_edge
			// shifted window has no right-hand column
			assign tap_sel = tap_q[c];
			assign tap_en  = ctl.active && !ctl.dc;
		end else begin : g_mid
			assign tap_sel = ctl.dc ? tap_q[c+1] : tap_q[c];
			assign tap_en  = ctl.active && !(ctl.zleft && (c == 0));
		end

		assign prod_c[c] = tap_en ? prod_t'(coef) * prod_t'(tap_sel) : '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3    <= prod_c;
			row_sum_s4 <= rsum_t'(prod_s3[0]) + rsum_t'(prod_s3[1]) + rsum_t'(prod_s3[2]);
		end
	end

	assign row_sum = row_sum_s4;

endmodule

@@ hdl/conv3x3_zero_padded_stream.sv @@
// top level: 3x3 zero-padded convolution over a raster pixel stream
// pipeline: a pixel transfer passes the line store read (s1), the window load (s2), the
//   products (s3) and the row sums (s4) before its first result reaches the output register
// throughput: one pixel per cycle while the output is not stalled; a pixel with k results holds
//   the issue stage until all k have issued (up to 4 at the frame end) on nine shared multipliers
// reset: counters, window taps, pipeline valids and registers to defaults; the line
//   store is not cleared and needs no clearing pass
module conv3x3_zero_padded_stream (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// pixel_value [15:0]
	input  logic [c3zs_pkg::IN_TDATA_W-1:0]       s_tdata,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// filtered_value [26:0], out_row [38:27], out_col [48:39], zero pad above
	output logic [c3zs_pkg::OUT_TDATA_W-1:0]      m_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic                                  m_tlast,
	// frame_last
	output logic                                  m_tuser,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [c3zs_pkg::APB_ADDR_W-1:0]       paddr,
	input  logic [c3zs_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [c3zs_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                  pready
);
	import c3zs_pkg::*;

	// configuration registers
	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;
	krow_t           kern_q [TAPS];
	reg_idx_t        reg_idx;
	logic            cfg_wr;

	// frame position
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [COL_W-1:0] wm1, j_cur;
	logic [ROW_W-1:0] hm1, i_cur;
	logic             last_col, last_row;
	logic [3:0]       rel_flags;
	logic             accept;

	// s1: line store read in flight
	logic             valid_s1;
	pixel_t           px_s1;
	logic [3:0]       flags_s1;
	logic [ROW_W-1:0] i_s1;
	logic [COL_W-1:0] j_s1;
	logic             ztop_s1, zleft_s1;
	logic [2*PIX_W-1:0] line_rd;

	// s2: window loaded, results issued one per cycle while the output is not stalled
	logic [3:0]       pend_s2;
	logic [ROW_W-1:0] i_s2;
	logic [COL_W-1:0] j_s2;
	logic             ztop_s2, zleft_s2;
	logic [1:0]       vsel;
	logic [3:0]       vbit;
	logic             single, issue, s2_free, load, adv;
	logic             dr, dc;

	pixel_t    cell_tap [TAPS];
	krow_t     cell_coef [TAPS];
	cell_ctl_t cell_ctl [TAPS];
	rsum_t     cell_sum [TAPS];

	// s3/s4 follow the cells' product and row sum registers
	logic             valid_s3, valid_s4;
	logic [ROW_W-1:0] orow_s3, orow_s4;
	logic [COL_W-1:0] ocol_s3, ocol_s4;
	logic             rlast_s3, rlast_s4, flast_s3, flast_s4;

	logic             out_valid_q;
	fsum_t            out_value_q;
	logic [ROW_W-1:0] out_row_q;
	logic [COL_W-1:0] out_col_q;
	logic             out_rlast_q, out_flast_q;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			kern_q         <= '{default: KROW_RST};
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[FH_W-1:0];
				REG_KERNEL_TOP:   kern_q[0]      <= pwdata[KROW_W-1:0];
				REG_KERNEL_MID:   kern_q[1]      <= pwdata[KROW_W-1:0];
				REG_KERNEL_BOT:   kern_q[2]      <= pwdata[KROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_q);
			REG_KERNEL_TOP:   prdata = APB_DATA_W'(kern_q[0]);
			REG_KERNEL_MID:   prdata = APB_DATA_W'(kern_q[1]);
			REG_KERNEL_BOT:   prdata = APB_DATA_W'(kern_q[2]);
			default:          prdata = '0;
		endcase
	end

	// ---------------- position and release flags ----------------
	always_comb begin
		if (frame_width_q < FW_W'(2)) begin
			wm1 = COL_W'(1);
		end else if (frame_width_q > FW_W'(MAX_WIDTH)) begin
			wm1 = COL_W'(MAX_WIDTH - 1);
		end else begin
			wm1 = COL_W'(frame_width_q - FW_W'(1));
		end
		if (frame_height_q < FH_W'(2)) begin
			hm1 = ROW_W'(1);
		end else if (frame_height_q > FH_W'(MAX_HEIGHT)) begin
			hm1 = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			hm1 = ROW_W'(frame_height_q - FH_W'(1));
		end
		// a size shrunk in mid-frame holds the counters to the last row or column
		j_cur    = (col_q > wm1) ? wm1 : col_q;
		i_cur    = (row_q > hm1) ? hm1 : row_q;
		last_col = (j_cur == wm1);
		last_row = (i_cur == hm1);
		rel_flags[0] = (i_cur != '0) && (j_cur != '0);
		rel_flags[1] = (i_cur != '0) && last_col;
		rel_flags[2] = last_row && (j_cur != '0);
		rel_flags[3] = last_row && last_col;
	end

	assign s_tready = !valid_s1 || load;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : i_cur + ROW_W'(1);
			end else begin
				col_q <= j_cur + COL_W'(1);
			end
		end
	end

	// ---------------- s1 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1    <= s_tdata[PIX_W-1:0];
			flags_s1 <= rel_flags;
			i_s1     <= i_cur;
			j_s1     <= j_cur;
			ztop_s1  <= (i_cur == ROW_W'(1));
			zleft_s1 <= (j_cur == COL_W'(1));
		end
	end

	// older row in the upper half, newer row in the lower half
	c3zs_ram #(
		.WIDTH (2 * PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (load),
		.waddr (j_s1),
		.wdata ({line_rd[PIX_W-1:0], px_s1}),
		.re    (accept),
		.raddr (j_cur),
		.rdata (line_rd)
	);

	// ---------------- s2: issue sequencer ----------------
	assign adv = !out_valid_q || m_tready;

	always_comb begin
		if (pend_s2[0]) begin
			vsel = 2'd0;
		end else if (pend_s2[1]) begin
			vsel = 2'd1;
		end else if (pend_s2[2]) begin
			vsel = 2'd2;
		end else begin
			vsel = 2'd3;
		end
		vbit    = 4'b0001 << vsel;
		single  = ((pend_s2 & (pend_s2 - 4'd1)) == 4'd0);
		issue   = adv && (pend_s2 != 4'd0);
		s2_free = (pend_s2 == 4'd0) || (issue && single);
		load    = s2_free && valid_s1;
		dr      = vsel[1];
		dc      = vsel[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s2 <= '0;
		end else if (load) begin
			pend_s2 <= flags_s1;
		end else if (issue) begin
			pend_s2 <= pend_s2 & ~vbit;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			i_s2     <= i_s1;
			j_s2     <= j_s1;
			ztop_s2  <= ztop_s1;
			zleft_s2 <= zleft_s1;
		end
	end

	// a result one row down uses the window shifted up, one column right shifted left
	always_comb begin
		cell_tap[0]  = line_rd[2*PIX_W-1:PIX_W];
		cell_tap[1]  = line_rd[PIX_W-1:0];
		cell_tap[2]  = px_s1;
		cell_coef[0] = kern_q[0];
		cell_coef[1] = dr ? kern_q[0] : kern_q[1];
		cell_coef[2] = dr ? kern_q[1] : kern_q[2];
		for (int k = 0; k < TAPS; k++) begin
			cell_ctl[k].dc    = dc;
			cell_ctl[k].zleft = zleft_s2 && !dc;
			cell_ctl[k].active = 1'b1;
		end
		cell_ctl[0].active = !dr && !ztop_s2;
	end

	for (genvar k = 0; k < TAPS; k++) begin : g_cell
		c3zs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (load),
			.adv      (adv),
			.tap_in   (cell_tap[k]),
			.coef_row (cell_coef[k]),
			.ctl      (cell_ctl[k]),
			.row_sum  (cell_sum[k])
		);
	end

	// ---------------- s3, s4 and output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s3    <= issue;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			orow_s3     <= dr ? i_s2 : i_s2 - ROW_W'(1);
			ocol_s3     <= dc ? j_s2 : j_s2 - COL_W'(1);
			rlast_s3    <= single;
			flast_s3    <= (vsel == 2'd3);
			orow_s4     <= orow_s3;
			ocol_s4     <= ocol_s3;
			rlast_s4    <= rlast_s3;
			flast_s4    <= flast_s3;
			out_value_q <= fsum_t'(cell_sum[0]) + fsum_t'(cell_sum[1]) + fsum_t'(cell_sum[2]);
			out_row_q   <= orow_s4;
			out_col_q   <= ocol_s4;
			out_rlast_q <= rlast_s4;
			out_flast_q <= flast_s4;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_col_q, out_row_q, out_value_q};
	assign m_tlast  = out_rlast_q;
	assign m_tuser  = out_flast_q;

endmodule
